// File: src/dlbd_pkg.sv
`timescale 1ns / 1ps

package dlbd_pkg;

    localparam int unsigned LANE_W   = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [LANE_W-1:0] HIGH_SEED_RESET = 64'hcbf2_9ce4_8422_2325;
    localparam logic [LANE_W-1:0] LOW_SEED_RESET  = 64'h9e37_79b9_7f4a_7c15;

    localparam int unsigned LOW_FOLD_SHIFT = 29;
    localparam int unsigned OUT_FOLD_SHIFT = 17;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SEED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SEED  = 8'd1;

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        lane_t high;
        lane_t low;
    } lane_pair_t;

    // One absorb step handed from the input stage to the lanes.
    typedef struct packed {
        logic  fire;
        logic  last;
        byte_t data_byte;
    } step_t;

    // Multiply by 0x100000001B3 mod 2^64 as a sum of shifted copies.
    function automatic lane_t mul_high_prime(input lane_t v);
        return (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 1) + v;
    endfunction

    // Multiply by 0x100000001B5 mod 2^64 as a sum of shifted copies.
    function automatic lane_t mul_low_prime(input lane_t v);
        return (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 2) + v;
    endfunction

    function automatic lane_t high_step(input lane_t acc, input byte_t b);
        return mul_high_prime(acc ^ {{(LANE_W-BYTE_W){1'b0}}, b});
    endfunction

    function automatic lane_t low_step(input lane_t acc, input byte_t b);
        lane_t t;
        t = acc + {{(LANE_W-BYTE_W){1'b0}}, b};
        t = t ^ (t >> LOW_FOLD_SHIFT);
        return mul_low_prime(t);
    endfunction

endpackage

// File: src/dlbd_intf.sv
`timescale 1ns / 1ps

interface dlbd_byte_if;
    logic                 valid;
    logic                 ready;
    dlbd_pkg::byte_t      data_byte;
    logic                 last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dlbd_digest_if;
    logic                 valid;
    logic                 ready;
    dlbd_pkg::lane_t      digest_high;
    dlbd_pkg::lane_t      digest_low;

    modport source (output valid, output digest_high, output digest_low, input ready);
    modport sink   (input valid, input digest_high, input digest_low, output ready);
endinterface

interface dlbd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dlbd_pkg::CFG_IDX_W-1:0]    index;
    dlbd_pkg::lane_t                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/dlbd_seed_regs.sv
`timescale 1ns / 1ps

module dlbd_seed_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    dlbd_cfg_if.sink              cfg,
    output dlbd_pkg::lane_pair_t  seeds
);

    dlbd_pkg::lane_pair_t seeds_reg;
    dlbd_pkg::lane_pair_t seeds_next;

    assign cfg.ready = 1'b1;
    assign seeds     = seeds_reg;

    always_comb
    begin
        seeds_next = seeds_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dlbd_pkg::REG_HIGH_SEED: seeds_next.high = cfg.data;
                dlbd_pkg::REG_LOW_SEED:  seeds_next.low  = cfg.data;
                default:                 seeds_next      = seeds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeds_reg.high <= dlbd_pkg::HIGH_SEED_RESET;
            seeds_reg.low  <= dlbd_pkg::LOW_SEED_RESET;
        end
        else
        begin
            seeds_reg <= seeds_next;
        end
    end

endmodule

// File: src/dlbd_lanes.sv
`timescale 1ns / 1ps

module dlbd_lanes (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dlbd_pkg::step_t       step,
    input  dlbd_pkg::lane_pair_t  seeds,
    output dlbd_pkg::lane_pair_t  digest
);

    dlbd_pkg::lane_pair_t acc_reg;
    dlbd_pkg::lane_pair_t acc_next;
    dlbd_pkg::lane_pair_t absorbed;

    always_comb
    begin
        absorbed.high = dlbd_pkg::high_step(acc_reg.high, step.data_byte);
        absorbed.low  = dlbd_pkg::low_step(acc_reg.low, step.data_byte);
    end

    // The digest is valid only when the step carries the last byte.
    assign digest.high = absorbed.high;
    assign digest.low  = absorbed.low ^ (absorbed.high >> dlbd_pkg::OUT_FOLD_SHIFT);

    always_comb
    begin
        acc_next = acc_reg;
        if (step.fire)
        begin
            acc_next = step.last ? seeds : absorbed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg.high <= dlbd_pkg::HIGH_SEED_RESET;
            acc_reg.low  <= dlbd_pkg::LOW_SEED_RESET;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: src/dual_lane_byte_digest_128.sv
`timescale 1ns / 1ps

// A 128-bit digest over a byte stream. Every byte beat on byte_in is absorbed
// into two 64-bit lanes (an FNV-1a style high lane and a folding low lane);
// a beat with last set closes the message, puts the digest on digest_out and
// reloads both lanes from the seed registers. The block takes one byte per
// cycle unless a last byte is stalled: the rate is set by the lane update,
// where each constant multiply is a short shift-and-add. A byte waits in the
// input register, and a last byte's digest is registered in the output
// register for digest_out. Bytes not marked last never wait on the output
// side; a last byte waits in the input register only while a previous
// digest is still held on digest_out. The seeds (index 0 high, 1 low) are
// written on cfg, which is always ready; other indexes are ignored. A new
// seed takes effect from the message after the next byte marked last, and
// seeds should only be written while the block is idle.
module dual_lane_byte_digest_128 (
    input  logic           clk,
    input  logic           rst_n,
    dlbd_byte_if.sink      byte_in,
    dlbd_digest_if.source  digest_out,
    dlbd_cfg_if.sink       cfg
);

    // Input register: one byte beat waiting to be absorbed.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  in_last_reg;
    dlbd_pkg::byte_t       in_byte_reg;

    // Output register: one finished digest waiting to be taken.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dlbd_pkg::lane_pair_t  out_digest_reg;

    dlbd_pkg::lane_pair_t  seeds;
    dlbd_pkg::lane_pair_t  digest;
    dlbd_pkg::step_t       step;
    logic                  advance;
    logic                  out_free;

    // The output register can take a new digest when it is empty or its
    // current beat is leaving in this cycle.
    assign out_free = !out_valid_reg || digest_out.ready;

    // A byte not marked last produces no result, so it always moves on.
    assign advance = in_valid_reg && (!in_last_reg || out_free);

    assign byte_in.ready = !in_valid_reg || advance;

    assign step.fire      = advance;
    assign step.last      = in_last_reg;
    assign step.data_byte = in_byte_reg;

    dlbd_seed_regs u_seed_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .seeds (seeds)
    );

    dlbd_lanes u_lanes (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .seeds  (seeds),
        .digest (digest)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_in.ready)
        begin
            in_valid_next = byte_in.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (digest_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.last;
        end
        if (advance && in_last_reg)
        begin
            out_digest_reg <= digest;
        end
    end

    assign digest_out.valid       = out_valid_reg;
    assign digest_out.digest_high = out_digest_reg.high;
    assign digest_out.digest_low  = out_digest_reg.low;

`ifndef SYNTHESIS
    // A digest only appears after a last byte was absorbed.
    a_digest_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("digest became valid without a last byte");

    // A byte held back in the input register keeps its last flag and value.
    a_input_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_last_reg) && $stable(in_byte_reg)))
        else $error("stalled input byte was lost or changed");

    // Only a last byte can be stalled, and only behind an unread digest.
    a_stall_reason : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (in_last_reg && out_valid_reg && !digest_out.ready))
        else $error("input stalled without a pending digest");
`endif

endmodule
